// ===== rtl/sto_pkg.sv =====
// shared constants and types for the strided tensor offset generator
package sto_pkg;
    localparam int NDIM       = 4;
    localparam int IDX_BITS   = 32;
    localparam int COORD_BITS = 16;
    localparam int OFF_BITS   = 50;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int IN_DATA_BITS  = 96;
    localparam int OUT_DATA_BITS = 120;

    localparam int RANK_DEF        = 4;
    localparam int SIZE_BITS_DEF   = 16;
    localparam int STRIDE_BITS_DEF = 32;

    localparam logic [1:0] OP_LIN = 2'd0;
    localparam logic [1:0] OP_CRD = 2'd1;
    localparam logic [1:0] OP_MAT = 2'd2;
    localparam logic [1:0] OP_BAD = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE0   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE1   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE2   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIZE3   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE0 = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE1 = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE2 = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_STRIDE3 = 3'd7;

    typedef struct packed {
        logic       vld;
        logic [1:0] op;
        logic       err;
    } t_ctl;
endpackage

// ===== rtl/sto_cell.sv =====
// one restoring division step cell of the coordinate decomposition chain
module sto_cell #(
    parameter int SIZE_BITS = sto_pkg::SIZE_BITS_DEF,
    parameter int CW        = 16,
    parameter int DIM       = 3,
    parameter bit FIRST     = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sto_pkg::t_ctl                 i_ctl,
    input  logic [sto_pkg::IDX_BITS-1:0]  i_q,
    input  logic [SIZE_BITS-1:0]          i_r,
    input  logic [CW-1:0]                 i_crd [sto_pkg::NDIM],
    input  logic [SIZE_BITS-1:0]          i_div,
    input  logic                          i_ready,
    output logic                          o_ready,
    output sto_pkg::t_ctl                 o_ctl,
    output logic [sto_pkg::IDX_BITS-1:0]  o_q,
    output logic [SIZE_BITS-1:0]          o_r,
    output logic [CW-1:0]                 o_crd [sto_pkg::NDIM]
);
    localparam int UP = (DIM < sto_pkg::NDIM - 1) ? DIM + 1 : DIM;

    sto_pkg::t_ctl                r_ctl;
    logic [sto_pkg::IDX_BITS-1:0] r_q, n_q;
    logic [SIZE_BITS-1:0]         r_r, n_r;
    logic [CW-1:0]                r_crd [sto_pkg::NDIM];
    logic [CW-1:0]                n_crd [sto_pkg::NDIM];
    logic [SIZE_BITS-1:0]         div_e;
    logic [SIZE_BITS-1:0]         r_start;
    logic [SIZE_BITS:0]           rs;
    logic [SIZE_BITS:0]           diff;
    logic                         ge;

    assign o_ready = !r_ctl.vld || i_ready;

    always_comb begin
        // matrix mode only decomposes over the two leading dimensions
        div_e   = (i_ctl.op == sto_pkg::OP_MAT && DIM >= 2) ? SIZE_BITS'(1) : i_div;
        r_start = FIRST ? '0 : i_r;
        rs      = {r_start, i_q[sto_pkg::IDX_BITS-1]};
        ge      = rs >= {1'b0, div_e};
        diff    = rs - {1'b0, div_e};
        n_r     = ge ? diff[SIZE_BITS-1:0] : rs[SIZE_BITS-1:0];
        n_q     = {i_q[sto_pkg::IDX_BITS-2:0], ge};
        n_crd   = i_crd;
        if (FIRST && DIM < sto_pkg::NDIM - 1 &&
            (i_ctl.op == sto_pkg::OP_LIN || i_ctl.op == sto_pkg::OP_MAT)) begin
            n_crd[UP] = CW'(i_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_q   <= n_q;
            r_r   <= n_r;
            r_crd <= n_crd;
        end
    end

    assign o_ctl = r_ctl;
    assign o_q   = r_q;
    assign o_r   = r_r;
    assign o_crd = r_crd;
endmodule

// ===== rtl/sto_mac.sv =====
// stride weighting and offset sum tail of the chain, with the output register
module sto_mac #(
    parameter int SIZE_BITS   = sto_pkg::SIZE_BITS_DEF,
    parameter int STRIDE_BITS = sto_pkg::STRIDE_BITS_DEF,
    parameter int CW          = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sto_pkg::t_ctl                  i_ctl,
    input  logic [sto_pkg::IDX_BITS-1:0]   i_q,
    input  logic [SIZE_BITS-1:0]           i_r,
    input  logic [CW-1:0]                  i_crd [sto_pkg::NDIM],
    input  logic [STRIDE_BITS-1:0]         i_stride [sto_pkg::NDIM],
    output logic                           o_ready,
    input  logic                           i_ready,
    output logic                           o_valid,
    output logic [sto_pkg::OFF_BITS-1:0]   o_offset,
    output logic [sto_pkg::COORD_BITS-1:0] o_coord [sto_pkg::NDIM],
    output logic                           o_err
);
    localparam int OB = sto_pkg::OFF_BITS;
    localparam int ND = sto_pkg::NDIM;

    sto_pkg::t_ctl          r_c1, r_c2, r_c3;
    logic [CW-1:0]          r_crd1 [ND];
    logic [CW-1:0]          r_crd2 [ND];
    logic [STRIDE_BITS-1:0] r_str1 [ND];
    logic [OB-1:0]          r_prod [ND];
    logic [OB-1:0]          r_off;
    logic [sto_pkg::COORD_BITS-1:0] r_co [ND];
    logic                   rdy1, rdy2, rdy3;
    sto_pkg::t_ctl          n_c1;
    logic [CW-1:0]          n_crd1 [ND];
    logic [STRIDE_BITS-1:0] n_str1 [ND];
    logic [OB-1:0]          n_off;

    assign rdy3    = !r_c3.vld || i_ready;
    assign rdy2    = !r_c2.vld || rdy3;
    assign rdy1    = !r_c1.vld || rdy2;
    assign o_ready = rdy1;

    always_comb begin
        n_c1   = i_ctl;
        n_crd1 = i_crd;
        // outermost remainder closes the decomposition
        if (i_ctl.op == sto_pkg::OP_LIN || i_ctl.op == sto_pkg::OP_MAT) begin
            n_crd1[0] = CW'(i_r);
        end
        // matrix index beyond dim0 x dim1 leaves a nonzero quotient
        if (i_ctl.op == sto_pkg::OP_MAT && i_q != '0) begin
            n_c1.err = 1'b1;
        end
        for (int d = 0; d < ND; d++) begin
            case (i_ctl.op)
                sto_pkg::OP_LIN, sto_pkg::OP_CRD: n_str1[d] = i_stride[d];
                sto_pkg::OP_MAT: n_str1[d] = (d < 2) ? i_stride[d] : '0;
                default:         n_str1[d] = '0;
            endcase
        end
        n_off = '0;
        for (int d = 0; d < ND; d++) begin
            n_off = n_off + r_prod[d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
        end else begin
            if (rdy1) r_c1 <= n_c1;
            if (rdy2) r_c2 <= r_c1;
            if (rdy3) r_c3 <= r_c2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_crd1 <= n_crd1;
            r_str1 <= n_str1;
        end
        if (rdy2) begin
            r_crd2 <= r_crd1;
            for (int d = 0; d < ND; d++) begin
                r_prod[d] <= OB'(r_crd1[d]) * OB'(r_str1[d]);
            end
        end
        if (rdy3) begin
            r_off <= n_off;
            for (int d = 0; d < ND; d++) begin
                r_co[d] <= (r_c2.op == sto_pkg::OP_LIN) ?
                           sto_pkg::COORD_BITS'(r_crd2[d]) : '0;
            end
        end
    end

    assign o_valid  = r_c3.vld;
    assign o_offset = r_off;
    assign o_coord  = r_co;
    assign o_err    = r_c3.err;
endmodule

// ===== rtl/strided_tensor_offset.sv =====
// top level of the strided tensor offset generator
// throughput: one transaction per cycle while m_axis_tready does not stall the pipeline,
// set by the chain of one-bit division cells
// (32 cells per dimension, innermost first) followed by multiply and sum stages
// reset: synchronous active low, clears all valid flags; sizes reset to 1,
// strides to 0 except the innermost which resets to 1
module strided_tensor_offset #(
    parameter int RANK        = sto_pkg::RANK_DEF,
    parameter int SIZE_BITS   = sto_pkg::SIZE_BITS_DEF,
    parameter int STRIDE_BITS = sto_pkg::STRIDE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sto_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [sto_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // linear_index[31:0], coord_in0..coord_in3 16 bits each
    input  logic [sto_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]                          s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // element_offset[49:0], coord_out0..coord_out3 16 bits each, zero fill
    output logic [sto_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // range_error
    output logic                                m_axis_tuser
);
    localparam int ND = sto_pkg::NDIM;
    localparam int CB = sto_pkg::COORD_BITS;
    localparam int CW = (SIZE_BITS > CB) ? SIZE_BITS : CB;
    localparam int STEPS = sto_pkg::IDX_BITS;
    localparam int NC = ND * STEPS;

    // configuration registers
    logic [SIZE_BITS-1:0]   r_size   [ND];
    logic [STRIDE_BITS-1:0] r_stride [ND];
    logic [SIZE_BITS-1:0]   eff_size   [ND];
    logic [STRIDE_BITS-1:0] eff_stride [ND];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < ND; d++) begin
                r_size[d]   <= SIZE_BITS'(1);
                r_stride[d] <= '0;
            end
            r_stride[ND-1] <= STRIDE_BITS'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sto_pkg::REG_SIZE0:   r_size[0]   <= SIZE_BITS'(i_cfg_data[15:0]);
                sto_pkg::REG_SIZE1:   r_size[1]   <= SIZE_BITS'(i_cfg_data[15:0]);
                sto_pkg::REG_SIZE2:   r_size[2]   <= SIZE_BITS'(i_cfg_data[15:0]);
                sto_pkg::REG_SIZE3:   r_size[3]   <= SIZE_BITS'(i_cfg_data[15:0]);
                sto_pkg::REG_STRIDE0: r_stride[0] <= STRIDE_BITS'(i_cfg_data);
                sto_pkg::REG_STRIDE1: r_stride[1] <= STRIDE_BITS'(i_cfg_data);
                sto_pkg::REG_STRIDE2: r_stride[2] <= STRIDE_BITS'(i_cfg_data);
                sto_pkg::REG_STRIDE3: r_stride[3] <= STRIDE_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // leading dimensions beyond the rank act as size 1, stride 0; zero size acts as 1
    always_comb begin
        for (int d = 0; d < ND; d++) begin
            if (d + RANK < ND) begin
                eff_size[d]   = SIZE_BITS'(1);
                eff_stride[d] = '0;
            end else begin
                eff_size[d]   = (r_size[d] == '0) ? SIZE_BITS'(1) : r_size[d];
                eff_stride[d] = r_stride[d];
            end
        end
    end

    // chain wiring, index 0 is the input side
    sto_pkg::t_ctl              c_ctl [NC+1];
    logic [STEPS-1:0]           c_q   [NC+1];
    logic [SIZE_BITS-1:0]       c_r   [NC+1];
    logic [CW-1:0]              c_crd [NC+1][ND];
    logic                       c_rdy [NC+1];
    logic [CB-1:0]              in_crd [ND];
    logic                       crd_err;
    logic [CB-1:0]              out_coord [ND];
    logic [sto_pkg::OFF_BITS-1:0] out_off;

    always_comb begin
        crd_err = 1'b0;
        for (int d = 0; d < ND; d++) begin
            in_crd[d] = s_axis_tdata[STEPS + d*CB +: CB];
            // coordinate mode flags any coordinate at or above its size
            if (CW'(in_crd[d]) >= CW'(eff_size[d])) crd_err = 1'b1;
            c_crd[0][d] = CW'(in_crd[d]);
        end
        c_ctl[0].vld = s_axis_tvalid;
        c_ctl[0].op  = s_axis_tuser;
        c_ctl[0].err = (s_axis_tuser == sto_pkg::OP_BAD) ||
                       (s_axis_tuser == sto_pkg::OP_CRD && crd_err);
        c_q[0] = s_axis_tdata[STEPS-1:0];
        c_r[0] = '0;
    end

    assign s_axis_tready = c_rdy[0];

    for (genvar k = 0; k < NC; k++) begin : g_cell
        localparam int DIM = ND - 1 - k / STEPS;
        sto_cell #(
            .SIZE_BITS (SIZE_BITS),
            .CW        (CW),
            .DIM       (DIM),
            .FIRST     ((k % STEPS) == 0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[k]),
            .i_q     (c_q[k]),
            .i_r     (c_r[k]),
            .i_crd   (c_crd[k]),
            .i_div   (eff_size[DIM]),
            .i_ready (c_rdy[k+1]),
            .o_ready (c_rdy[k]),
            .o_ctl   (c_ctl[k+1]),
            .o_q     (c_q[k+1]),
            .o_r     (c_r[k+1]),
            .o_crd   (c_crd[k+1])
        );
    end

    sto_mac #(
        .SIZE_BITS   (SIZE_BITS),
        .STRIDE_BITS (STRIDE_BITS),
        .CW          (CW)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (c_ctl[NC]),
        .i_q      (c_q[NC]),
        .i_r      (c_r[NC]),
        .i_crd    (c_crd[NC]),
        .i_stride (eff_stride),
        .o_ready  (c_rdy[NC]),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_offset (out_off),
        .o_coord  (out_coord),
        .o_err    (m_axis_tuser)
    );

    assign m_axis_tdata = {6'd0, out_coord[3], out_coord[2], out_coord[1], out_coord[0],
                           out_off};
endmodule
